[rtl/m2h_pkg.sv]
// m2h_pkg: shared types and constants of the streaming murmur key hasher
// holds mixing constants, channel payload structs, micro-op codes and the
// sequencer-to-datapath control struct; depends on nothing
package m2h_pkg;

  // mixing multipliers; the 32-bit multiplier is also the low word of the 64-bit one
  localparam logic [63:0] MIX_MUL64  = 64'hc6a4a7935bd1e995;
  localparam logic [31:0] MIX_MUL32  = 32'h5bd1e995;
  localparam logic [31:0] MIX_MUL_HI = MIX_MUL64[63:32];

  // shift amounts
  localparam int unsigned SHIFT_R64   = 47;
  localparam int unsigned SHIFT_R32   = 24;
  localparam int unsigned SHIFT_FIN_A = 13;
  localparam int unsigned SHIFT_FIN_B = 15;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_VARIANT_MODE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HASH_SEED    = 1'b1;

  typedef struct packed {
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        first_chunk;
    logic        last_chunk;
    logic [31:0] key_length;
  } key_chunk_t;

  typedef struct packed {
    logic [63:0] hash_value;
    logic        length_mismatch;
  } hash_result_t;

  // one micro-op is one pass through the shared multiplier, but for 32-bit seeding
  typedef enum logic [3:0] {
    OP_SEED,      // h = (klen * m) ^ seed
    OP_K_WORD,    // k = word * m
    OP_K_HIGH,    // k = word[63:32] * m
    OP_K_SHIFT,   // k = (k ^ k >> r) * m
    OP_H_XK_MUL,  // h = (h ^ k) * m
    OP_H_MUL_XK,  // h = (h * m) ^ k
    OP_H_TAIL_LO, // h = (h ^ word) * m
    OP_H_TAIL_HI, // h = (h ^ word[63:32]) * m
    OP_H_FIN      // h = (h ^ h >> a) * m, then h ^= h >> b
  } op_t;

  typedef struct packed {
    op_t  op;
    logic issue;   // start the multiplier on this op
    logic direct;  // 32-bit seeding, no multiply
    logic load;    // move the finished hash into the output register
  } seq_ctl_t;

endpackage

[rtl/m2h_mul.sv]
// m2h_mul: the shared multiplier, one 32x32 product per cycle
// forms x * 0xc6a4a7935bd1e995 (low 64 bits) in three products or the low 32 bits of x[31:0] * 0x5bd1e995 in one
// uses m2h_pkg
module m2h_mul
  import m2h_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        wide,
  input  logic [63:0] operand,
  output logic        done,
  output logic [63:0] product
);

  logic        busy;
  logic [1:0]  step;
  logic        wide_q;
  logic [31:0] opnd_lo;
  logic [31:0] opnd_hi;
  logic [63:0] prod;
  logic [63:0] acc;
  logic [31:0] mul_a;
  logic [31:0] mul_b;

  // lo*lo on start, lo*hi on step 1, hi*lo on step 2
  always_comb begin
    if (start) begin
      mul_a = operand[31:0];
      mul_b = MIX_MUL32;
    end else if (step == 2'd1) begin
      mul_a = opnd_lo;
      mul_b = MIX_MUL_HI;
    end else begin
      mul_a = opnd_hi;
      mul_b = MIX_MUL32;
    end
  end

  assign done    = busy && (wide_q ? (step == 2'd3) : (step == 2'd1));
  assign product = wide_q ? {acc[63:32] + prod[31:0], acc[31:0]} : {32'd0, prod[31:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= 2'd0;
    end else if (start) begin
      busy <= 1'b1;
      step <= 2'd1;
    end else if (done) begin
      busy <= 1'b0;
    end else if (busy) begin
      step <= step + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      wide_q  <= wide;
      opnd_lo <= operand[31:0];
      opnd_hi <= operand[63:32];
    end
    prod <= 64'(mul_a) * 64'(mul_b);
    if (busy && step == 2'd1) begin
      acc <= prod;
    end else if (busy && step == 2'd2) begin
      acc[63:32] <= acc[63:32] + prod[31:0];
    end
  end

endmodule

[rtl/m2h_seq.sv]
// m2h_seq: micro-op sequencer, walks the mixing steps of one chunk
// plans seed, block, tail and finalise phases at the transfer; uses m2h_pkg
module m2h_seq
  import m2h_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       wide,
  input  logic       first,
  input  logic       last,
  input  logic [3:0] nbytes,
  input  logic       mul_done,
  input  logic       out_free,
  output seq_ctl_t   ctl,
  output logic       idle
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SEED, ST_A_K, ST_A_S, ST_A_H, ST_B_K, ST_B_S, ST_B_H,
    ST_TAIL, ST_FIN, ST_OUT
  } state_t;

  typedef struct packed {
    logic blk_a;
    logic blk_b;
    logic tail;
    logic tail_hi;
    logic fin;
  } plan_t;

  state_t     state;
  logic       launched;
  plan_t      plan;
  plan_t      plan_next;
  logic       full;
  logic       ge4;
  logic [2:0] tail_n;
  logic       phase;

  function automatic state_t next_phase(state_t cur, plan_t p);
    state_t nxt;
    nxt = ST_IDLE;
    unique case (cur)
      ST_IDLE, ST_SEED: begin
        priority if (p.blk_a) nxt = ST_A_K;
        else if (p.blk_b)     nxt = ST_B_K;
        else if (p.tail)      nxt = ST_TAIL;
        else if (p.fin)       nxt = ST_FIN;
        else                  nxt = ST_IDLE;
      end
      ST_A_K: nxt = ST_A_S;
      ST_A_S: nxt = ST_A_H;
      ST_A_H: begin
        priority if (p.blk_b) nxt = ST_B_K;
        else if (p.tail)      nxt = ST_TAIL;
        else if (p.fin)       nxt = ST_FIN;
        else                  nxt = ST_IDLE;
      end
      ST_B_K: nxt = ST_B_S;
      ST_B_S: nxt = ST_B_H;
      ST_B_H: begin
        priority if (p.tail) nxt = ST_TAIL;
        else if (p.fin)      nxt = ST_FIN;
        else                 nxt = ST_IDLE;
      end
      ST_TAIL: nxt = ST_FIN;
      ST_FIN:  nxt = ST_OUT;
      ST_OUT:  nxt = ST_IDLE;
      default: nxt = ST_IDLE;
    endcase
    return nxt;
  endfunction

  // phase plan from mode, last flag and byte count
  always_comb begin
    full   = (nbytes == 4'd8);
    ge4    = (nbytes >= 4'd4);
    tail_n = ge4 ? 3'(nbytes - 4'd4) : nbytes[2:0];
    plan_next.blk_a   = !last || (wide ? full : ge4);
    plan_next.blk_b   = !wide && (!last || full);
    plan_next.tail    = last && (wide ? (nbytes != 4'd0 && !full)
                                      : (tail_n != 3'd0 && tail_n != 3'd4));
    plan_next.tail_hi = !wide && ge4;
    plan_next.fin     = last;
  end

  assign phase = (state != ST_IDLE) && (state != ST_OUT);
  assign idle  = (state == ST_IDLE);

  always_comb begin
    ctl.direct = (state == ST_SEED) && !wide;
    ctl.issue  = phase && !launched && !ctl.direct;
    ctl.load   = (state == ST_OUT) && out_free;
    unique case (state)
      ST_SEED:         ctl.op = OP_SEED;
      ST_A_K:          ctl.op = OP_K_WORD;
      ST_A_S, ST_B_S:  ctl.op = OP_K_SHIFT;
      ST_A_H:          ctl.op = wide ? OP_H_XK_MUL : OP_H_MUL_XK;
      ST_B_K:          ctl.op = OP_K_HIGH;
      ST_B_H:          ctl.op = OP_H_MUL_XK;
      ST_TAIL:         ctl.op = plan.tail_hi ? OP_H_TAIL_HI : OP_H_TAIL_LO;
      default:         ctl.op = OP_H_FIN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      launched <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            plan     <= plan_next;
            state    <= first ? ST_SEED : next_phase(ST_IDLE, plan_next);
            launched <= 1'b0;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          if (ctl.direct || mul_done) begin
            state    <= next_phase(state, plan);
            launched <= 1'b0;
          end else if (ctl.issue) begin
            launched <= 1'b1;
          end
        end
      endcase
    end
  end

endmodule

[rtl/m2h_dp.sv]
// m2h_dp: hash datapath, running hash and block registers
// selects the multiplier operand per micro-op and writes the product back
// uses m2h_pkg
module m2h_dp
  import m2h_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  logic        wide,
  input  logic [63:0] word_in,
  input  logic [31:0] klen_in,
  input  logic [63:0] seed,
  input  seq_ctl_t    ctl,
  input  logic        mul_done,
  input  logic [63:0] mul_product,
  output logic [63:0] operand,
  output logic [63:0] hash
);

  logic [63:0] h;
  logic [63:0] k;
  logic [63:0] word;
  logic [31:0] klen;
  logic [63:0] hn;
  logic [63:0] hi_word;
  logic [63:0] k_shift;
  logic [63:0] fin_pre;
  logic [63:0] fin_post;
  logic [63:0] h_wb;
  logic        k_dest;

  always_comb begin
    // 32-bit mode sees only the low half of the running hash
    hn       = wide ? h : {32'd0, h[31:0]};
    hi_word  = {32'd0, word[63:32]};
    k_shift  = k ^ (wide ? (k >> SHIFT_R64) : (k >> SHIFT_R32));
    fin_pre  = hn ^ (wide ? (hn >> SHIFT_R64) : (hn >> SHIFT_FIN_A));
    fin_post = mul_product ^ (wide ? (mul_product >> SHIFT_R64)
                                   : (mul_product >> SHIFT_FIN_B));
    unique case (ctl.op)
      OP_SEED:      operand = {32'd0, klen};
      OP_K_WORD:    operand = word;
      OP_K_HIGH:    operand = hi_word;
      OP_K_SHIFT:   operand = k_shift;
      OP_H_XK_MUL:  operand = hn ^ k;
      OP_H_MUL_XK:  operand = hn;
      OP_H_TAIL_LO: operand = hn ^ word;
      OP_H_TAIL_HI: operand = hn ^ hi_word;
      OP_H_FIN:     operand = fin_pre;
      default:      operand = hn;
    endcase
    unique case (ctl.op)
      OP_SEED:     h_wb = mul_product ^ seed;
      OP_H_MUL_XK: h_wb = mul_product ^ k;
      OP_H_FIN:    h_wb = fin_post;
      default:     h_wb = mul_product;
    endcase
    k_dest = (ctl.op == OP_K_WORD) || (ctl.op == OP_K_HIGH) || (ctl.op == OP_K_SHIFT);
  end

  assign hash = h;

  always_ff @(posedge clk) begin
    if (rst) begin
      h <= '0;
    end else if (ctl.direct) begin
      h <= {32'd0, seed[31:0] ^ klen};
    end else if (mul_done && !k_dest) begin
      h <= h_wb;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word <= word_in;
      klen <= klen_in;
    end
    if (mul_done && k_dest) begin
      k <= mul_product;
    end
  end

endmodule

[rtl/murmur2_key_hash.sv]
// murmur2_key_hash: streaming murmur key hasher, top level
// holds configuration, length bookkeeping and the output register;
// instantiates m2h_seq, m2h_mul and m2h_dp, uses m2h_pkg
//
//   channel   | handshake              | payload
//   ----------+------------------------+-----------------------------
//   key       | key_valid / key_ready  | key_chunk   (key_chunk_t)
//   hash      | hash_valid / hash_ready| hash_result (hash_result_t)
//   cfg       | cfg_we                 | cfg_index, cfg_wdata
//
// a chunk transfers, then each mixing step takes one pass of the shared 32x32
// multiplier, but for 32-bit seeding, which needs no multiply; a first chunk adds
// the seed step and a last chunk the finalise step
// a short last chunk skips the block steps it has no bytes for
// a last chunk then moves the hash into the output register; that
// register holds a result while the next chunk is taken, and the chunk after a
// last one waits only if the previous hash has not been taken yet
// reset is synchronous: mode returns to 64-bit, seed and running state to zero
module murmur2_key_hash
  import m2h_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]            cfg_wdata,
  input  logic                   key_valid,
  output logic                   key_ready,
  input  key_chunk_t             key_chunk,
  output logic                   hash_valid,
  input  logic                   hash_ready,
  output hash_result_t           hash_result
);

  // configuration registers
  logic        variant_mode;
  logic [63:0] hash_seed;

  // per-key bookkeeping
  logic [31:0] bytes_seen;
  logic [31:0] expected_length;
  logic        error_seen;
  logic        mismatch;

  // next-value terms computed in the transfer cycle
  logic        accept;
  logic [3:0]  nbytes;
  logic [63:0] word_masked;
  logic [31:0] bytes_seen_next;
  logic [31:0] expected_length_next;
  logic        error_seen_next;

  // internal links
  seq_ctl_t    ctl;
  logic        seq_idle;
  logic        out_free;
  logic        mul_done;
  logic [63:0] mul_product;
  logic [63:0] operand;
  logic [63:0] hash;

  assign key_ready = seq_idle;
  assign accept    = key_valid && key_ready;
  assign out_free  = !hash_valid || hash_ready;

  always_comb begin
    // an oversized count is clamped to a full chunk
    nbytes = (key_chunk.byte_count > 4'd8) ? 4'd8 : key_chunk.byte_count;
    // bytes at or above the count read as zero
    for (int i = 0; i < 8; i++) begin
      word_masked[8*i +: 8] = (4'(i) < nbytes) ? key_chunk.data_word[8*i +: 8] : 8'd0;
    end
    expected_length_next = key_chunk.first_chunk ? key_chunk.key_length : expected_length;
    bytes_seen_next      = (key_chunk.first_chunk ? 32'd0 : bytes_seen) + {28'd0, nbytes};
    error_seen_next      = (!key_chunk.first_chunk && error_seen)
                           || (key_chunk.byte_count > 4'd8)
                           || (!key_chunk.last_chunk && nbytes != 4'd8);
  end

  // configuration writes, expected only while idle
  always_ff @(posedge clk) begin
    if (rst) begin
      variant_mode <= 1'b1;
      hash_seed    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VARIANT_MODE: variant_mode <= cfg_wdata[0];
        CFG_HASH_SEED:    hash_seed    <= cfg_wdata;
        default:          ;
      endcase
    end
  end

  // length tracking across chunks of a key
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen      <= '0;
      expected_length <= '0;
      error_seen      <= 1'b0;
    end else if (accept) begin
      bytes_seen      <= bytes_seen_next;
      expected_length <= expected_length_next;
      error_seen      <= error_seen_next;
    end
  end

  // mismatch verdict of the chunk in flight, only meaningful on a last chunk
  always_ff @(posedge clk) begin
    if (accept) begin
      mismatch <= error_seen_next || (bytes_seen_next != expected_length_next);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_valid <= 1'b0;
    end else if (ctl.load) begin
      hash_valid <= 1'b1;
    end else if (hash_ready) begin
      hash_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      hash_result.hash_value      <= hash;
      hash_result.length_mismatch <= mismatch;
    end
  end

  m2h_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .wide     (variant_mode),
    .first    (key_chunk.first_chunk),
    .last     (key_chunk.last_chunk),
    .nbytes   (nbytes),
    .mul_done (mul_done),
    .out_free (out_free),
    .ctl      (ctl),
    .idle     (seq_idle)
  );

  m2h_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (ctl.issue),
    .wide    (variant_mode),
    .operand (operand),
    .done    (mul_done),
    .product (mul_product)
  );

  m2h_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .load        (accept),
    .wide        (variant_mode),
    .word_in     (word_masked),
    .klen_in     (key_chunk.key_length),
    .seed        (hash_seed),
    .ctl         (ctl),
    .mul_done    (mul_done),
    .mul_product (mul_product),
    .operand     (operand),
    .hash        (hash)
  );

endmodule

[rtl/m2h_chk.sv]
// m2h_chk: port-level checks for murmur2_key_hash, attached by bind
// watches the key and hash channels only; uses m2h_pkg
module m2h_chk
  import m2h_pkg::*;
(
  input logic         clk,
  input logic         rst,
  input logic         key_valid,
  input logic         key_ready,
  input logic         hash_valid,
  input logic         hash_ready,
  input hash_result_t hash_result
);

  // a stalled result holds
  a_hash_hold: assert property (@(posedge clk) disable iff (rst)
    hash_valid && !hash_ready |=> hash_valid && $stable(hash_result))
    else $error("hash result changed while stalled");

  // a chunk transfer always leaves the block busy in the cycle after it
  a_busy_after_key: assert property (@(posedge clk) disable iff (rst)
    key_valid && key_ready |=> !key_ready)
    else $error("key ready right after a chunk transfer");

  // a new result is only loaded while a chunk is being worked on
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(hash_valid) |-> $past(!key_ready))
    else $error("result appeared while idle");

  // reset empties the output register
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !hash_valid)
    else $error("result valid after reset");

endmodule

bind murmur2_key_hash m2h_chk u_chk (
  .clk         (clk),
  .rst         (rst),
  .key_valid   (key_valid),
  .key_ready   (key_ready),
  .hash_valid  (hash_valid),
  .hash_ready  (hash_ready),
  .hash_result (hash_result)
);
